### hw/rtl/rhtc_pkg.sv
// ----------------------------------------------------------------------------
// rhtc_pkg
// Shared types and constants for the rgb to hsl tone classifier.
// ----------------------------------------------------------------------------
package rhtc_pkg;

	// input item and result item
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [14:0] hue;
		logic [10:0] saturation;
		logic [8:0]  lightness_sum;
		logic [1:0]  tone_class;
	} result_t;

	// configuration registers, as seen by the datapath
	typedef struct packed {
		logic [7:0] equal_tolerance;
		logic [8:0] dark_sum_limit;
		logic [8:0] white_sum_threshold;
		logic [8:0] black_sum_threshold;
	} cfg_t;

	// register indexes
	localparam logic [1:0] REG_EQUAL_TOL = 2'd0;
	localparam logic [1:0] REG_DARK_SUM  = 2'd1;
	localparam logic [1:0] REG_WHITE_SUM = 2'd2;
	localparam logic [1:0] REG_BLACK_SUM = 2'd3;

	// tone codes
	localparam logic [1:0] TONE_BLACK = 2'd0;
	localparam logic [1:0] TONE_OTHER = 2'd1;
	localparam logic [1:0] TONE_WHITE = 2'd2;

	// hue sector selection
	typedef enum logic [2:0] {
		RULE_NONE,
		RULE_RED_POS,
		RULE_RED_NEG,
		RULE_GREEN,
		RULE_BLUE
	} hue_rule_t;

	localparam logic [8:0]  SUM_MID    = 9'd255;
	localparam logic [8:0]  SUM_FULL   = 9'd510;
	localparam logic [22:0] HUE_SECTOR = 23'd3840;
	localparam int          DIV_STEPS  = 15;
	localparam int          LATENCY    = DIV_STEPS + 3;
	localparam int          QUO_W      = 15;

	// state of both dividers as it travels down the pipeline
	typedef struct packed {
		logic [7:0]       h_rem;
		logic [QUO_W-1:0] h_sh;
		logic [7:0]       h_div;
		logic [7:0]       s_rem;
		logic [QUO_W-1:0] s_sh;
		logic [7:0]       s_div;
		logic [8:0]       lsum;
		logic [1:0]       tone;
	} div_t;

endpackage

### hw/rtl/rgb_to_hsl_tone_classifier.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_tone_classifier
// RGB pixel to integer hue, saturation, lightness sum and tone class.
//
//   channel   signals                        handshake
//   pixel     start, busy, pixel             taken when start and !busy
//   result    done, result                   one-cycle strobe, no backpressure
//   config    psel penable pwrite paddr ...  APB, pready always high
//
// One pixel per clock; busy is never raised.
// The pipeline is three front stages plus fifteen divider steps,
// one quotient bit per step, hue and saturation dividers side by side.
// Reset clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module rgb_to_hsl_tone_classifier (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  rhtc_pkg::pixel_t  pixel,
	output logic              done,
	output rhtc_pkg::result_t result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import rhtc_pkg::*;

	cfg_t cfg_q;
	logic cfg_wr;

	logic valid_p [0:DIV_STEPS];
	div_t div_p   [0:DIV_STEPS];

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.equal_tolerance     <= 8'd3;
			cfg_q.dark_sum_limit      <= 9'd6;
			cfg_q.white_sum_threshold <= 9'd255;
			cfg_q.black_sum_threshold <= 9'd102;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_EQUAL_TOL: cfg_q.equal_tolerance     <= pwdata[7:0];
				REG_DARK_SUM:  cfg_q.dark_sum_limit      <= pwdata[8:0];
				REG_WHITE_SUM: cfg_q.white_sum_threshold <= pwdata[8:0];
				REG_BLACK_SUM: cfg_q.black_sum_threshold <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (paddr[3:2])
			REG_EQUAL_TOL: prdata = {24'b0, cfg_q.equal_tolerance};
			REG_DARK_SUM:  prdata = {23'b0, cfg_q.dark_sum_limit};
			REG_WHITE_SUM: prdata = {23'b0, cfg_q.white_sum_threshold};
			REG_BLACK_SUM: prdata = {23'b0, cfg_q.black_sum_threshold};
			default:       prdata = 32'b0;
		endcase
	end

	assign busy = 1'b0;

	// front stages
	rhtc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.pixel     (pixel),
		.cfg       (cfg_q),
		.out_valid (valid_p[0]),
		.out_div   (div_p[0])
	);

	// divider pipeline
	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		rhtc_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_p[i]),
			.in_div    (div_p[i]),
			.out_valid (valid_p[i+1]),
			.out_div   (div_p[i+1])
		);
	end

	// result item
	assign done                 = valid_p[DIV_STEPS];
	assign result.hue           = div_p[DIV_STEPS].h_sh;
	assign result.saturation    = div_p[DIV_STEPS].s_sh[10:0];
	assign result.lightness_sum = div_p[DIV_STEPS].lsum;
	assign result.tone_class    = div_p[DIV_STEPS].tone;

endmodule

### hw/rtl/rhtc_front.sv
// ----------------------------------------------------------------------------
// rhtc_front
// Three register stages: channel extremes, hue sector and saturation
// divisor selection, then the numerators that seed the dividers.
// ----------------------------------------------------------------------------
module rhtc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  rhtc_pkg::pixel_t pixel,
	input  rhtc_pkg::cfg_t  cfg,
	output logic            out_valid,
	output rhtc_pkg::div_t  out_div
);
	import rhtc_pkg::*;

	// stage 1 signals
	logic [7:0] mx, mn;
	logic       valid_s1;
	pixel_t     pix_s1;
	logic [7:0] max_s1, dif_s1;
	logic [8:0] sum_s1;

	// stage 2 signals
	hue_rule_t  rule;
	logic [10:0] u;
	logic       hzero, szero;
	logic [8:0] den;
	logic [1:0] tone;
	logic       valid_s2;
	logic [10:0] u_s2;
	logic [7:0] hdiv_s2, snum_s2, sdiv_s2;
	logic [8:0] sum_s2;
	logic [1:0] tone_s2;

	logic [22:0] hnum;
	logic        valid_s3;
	div_t        div_s3;

	// channel extremes
	always_comb begin
		mx = pixel.red;
		mn = pixel.red;
		if (pixel.green > mx) mx = pixel.green;
		if (pixel.blue > mx) mx = pixel.blue;
		if (pixel.green < mn) mn = pixel.green;
		if (pixel.blue < mn) mn = pixel.blue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		pix_s1 <= pixel;
		max_s1 <= mx;
		dif_s1 <= mx - mn;
		sum_s1 <= {1'b0, mx} + {1'b0, mn};
	end

	// hue sector, first matching rule wins
	always_comb begin
		if (dif_s1 < cfg.equal_tolerance || dif_s1 == 8'd0) rule = RULE_NONE;
		else if ((max_s1 - pix_s1.red) < cfg.equal_tolerance) begin
			if (pix_s1.green >= pix_s1.blue) rule = RULE_RED_POS;
			else rule = RULE_RED_NEG;
		end else if ((max_s1 - pix_s1.green) < cfg.equal_tolerance) rule = RULE_GREEN;
		else if ((max_s1 - pix_s1.blue) < cfg.equal_tolerance) rule = RULE_BLUE;
		else rule = RULE_NONE;
	end

	// hue in sixths of a turn times d
	always_comb begin
		hzero = 1'b0;
		case (rule)
			RULE_RED_POS: u = {3'b0, pix_s1.green - pix_s1.blue};
			RULE_RED_NEG: u = {2'b0, dif_s1, 1'b0} + {1'b0, dif_s1, 2'b0}
				- {3'b0, pix_s1.blue - pix_s1.green};
			RULE_GREEN: u = {2'b0, dif_s1, 1'b0} + {3'b0, pix_s1.blue}
				- {3'b0, pix_s1.red};
			RULE_BLUE: u = {1'b0, dif_s1, 2'b0} + {3'b0, pix_s1.red}
				- {3'b0, pix_s1.green};
			default: begin
				u = 11'd0;
				hzero = 1'b1;
			end
		endcase
	end

	// saturation divisor and tone class
	always_comb begin
		den = (sum_s1 <= SUM_MID) ? sum_s1 : (SUM_FULL - sum_s1);
		szero = (sum_s1 < cfg.dark_sum_limit) || (dif_s1 < cfg.equal_tolerance)
			|| (den == 9'd0);
		if (sum_s1 > cfg.white_sum_threshold) tone = TONE_WHITE;
		else if (sum_s1 < cfg.black_sum_threshold) tone = TONE_BLACK;
		else tone = TONE_OTHER;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		u_s2    <= u;
		hdiv_s2 <= hzero ? 8'd1 : dif_s1;
		snum_s2 <= szero ? 8'd0 : dif_s1;
		sdiv_s2 <= szero ? 8'd1 : den[7:0];
		sum_s2  <= sum_s1;
		tone_s2 <= tone;
	end

	// divider seeds: upper numerator bits start the remainder
	assign hnum = {12'b0, u_s2} * HUE_SECTOR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s3 <= 1'b0;
		else valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		div_s3.h_rem <= hnum[22:15];
		div_s3.h_sh  <= hnum[14:0];
		div_s3.h_div <= hdiv_s2;
		div_s3.s_rem <= {5'b0, snum_s2[7:5]};
		div_s3.s_sh  <= {snum_s2[4:0], 10'b0};
		div_s3.s_div <= sdiv_s2;
		div_s3.lsum  <= sum_s2;
		div_s3.tone  <= tone_s2;
	end

	assign out_valid = valid_s3;
	assign out_div   = div_s3;

endmodule

### hw/rtl/rhtc_div_step.sv
// ----------------------------------------------------------------------------
// rhtc_div_step
// One registered restoring-division step for both hue and saturation.
// ----------------------------------------------------------------------------
module rhtc_div_step (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  rhtc_pkg::div_t in_div,
	output logic           out_valid,
	output rhtc_pkg::div_t out_div
);
	import rhtc_pkg::*;

	logic [8:0] h_try, s_try;
	logic       h_ge, s_ge;
	logic       valid_q;
	div_t       div_q;

	// shift in next numerator bit, subtract when it fits
	always_comb begin
		h_try = {in_div.h_rem, in_div.h_sh[QUO_W-1]};
		s_try = {in_div.s_rem, in_div.s_sh[QUO_W-1]};
		h_ge  = h_try >= {1'b0, in_div.h_div};
		s_ge  = s_try >= {1'b0, in_div.s_div};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		div_q.h_rem <= h_ge ? 8'(h_try - {1'b0, in_div.h_div}) : h_try[7:0];
		div_q.h_sh  <= {in_div.h_sh[QUO_W-2:0], h_ge};
		div_q.h_div <= in_div.h_div;
		div_q.s_rem <= s_ge ? 8'(s_try - {1'b0, in_div.s_div}) : s_try[7:0];
		div_q.s_sh  <= {in_div.s_sh[QUO_W-2:0], s_ge};
		div_q.s_div <= in_div.s_div;
		div_q.lsum  <= in_div.lsum;
		div_q.tone  <= in_div.tone;
	end

	assign out_valid = valid_q;
	assign out_div   = div_q;

endmodule

### hw/rtl/rhtc_checker.sv
// ----------------------------------------------------------------------------
// rhtc_checker
// Port-level checks on timing and result ranges of the classifier.
// ----------------------------------------------------------------------------
module rhtc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input rhtc_pkg::result_t result
);
	import rhtc_pkg::*;

	// every item yields a result after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("item lost in pipeline");

	// no result without an item accepted earlier
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without item");

	// result ranges
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.hue <= 15'd23039 && result.saturation <= 11'd1024
			&& result.lightness_sum <= SUM_FULL)
		else $error("result out of range");

	// tone class follows lightness extremes
	a_tone: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.tone_class != 2'd3
			&& !(result.lightness_sum == SUM_FULL && result.tone_class == TONE_BLACK))
		else $error("bad tone class");

endmodule

bind rgb_to_hsl_tone_classifier rhtc_checker u_rhtc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

### tb/sv/rgb_to_hsl_tone_classifier_tb.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_tone_classifier_tb
// Self-checking bench for the rgb to hsl tone classifier. Pixels go in with
// random gaps, a scoreboard predicts hue, saturation, lightness sum and tone
// class for each accepted pixel and checks every result strobe in order.
// Several register settings are applied between phases over the apb port.
// ----------------------------------------------------------------------------
module rgb_to_hsl_tone_classifier_tb;
	import rhtc_pkg::*;

	// expected hsl results for accepted pixels
	class hsl_scoreboard;
		logic [7:0] tol;
		logic [8:0] dark_lim, white_thr, black_thr;
		result_t    pending[$];
		int         errors;

		function new();
			tol = 8'd3; dark_lim = 9'd6; white_thr = 9'd255; black_thr = 9'd102;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_EQUAL_TOL: tol       = val[7:0];
				REG_DARK_SUM:  dark_lim  = val[8:0];
				REG_WHITE_SUM: white_thr = val[8:0];
				REG_BLACK_SUM: black_thr = val[8:0];
				default: ;
			endcase
		endfunction

		// compute expected hsl values for one pixel
		function void note_pixel(pixel_t p);
			int unsigned r, g, b, mx, mn, d, s, den, h, sat;
			result_t     e;
			r = p.red; g = p.green; b = p.blue;
			mx = r; mn = r;
			if (g > mx) mx = g;
			if (b > mx) mx = b;
			if (g < mn) mn = g;
			if (b < mn) mn = b;
			d = mx - mn; s = mx + mn;
			h = 0;
			if (d >= tol && d != 0) begin
				if (mx - r < tol) begin
					if (g >= b) h = (3840 * (g - b)) / d;
					else h = (23040 * d - 3840 * (b - g)) / d;
				end else if (mx - g < tol) h = (7680 * d + 3840 * b - 3840 * r) / d;
				else if (mx - b < tol) h = (15360 * d + 3840 * r - 3840 * g) / d;
			end
			sat = 0;
			if (!(s < dark_lim || d < tol)) begin
				den = (s <= 255) ? s : 510 - s;
				if (den != 0) sat = (1024 * d) / den;
			end
			e.hue = h[14:0];
			e.saturation = sat[10:0];
			e.lightness_sum = s[8:0];
			if (s > white_thr) e.tone_class = TONE_WHITE;
			else if (s < black_thr) e.tone_class = TONE_BLACK;
			else e.tone_class = TONE_OTHER;
			pending.push_back(e);
		endfunction

		function void check_result(result_t got);
			result_t e;
			if (pending.size() == 0) begin
				report("result with nothing pending", 0, 0);
				return;
			end
			e = pending.pop_front();
			if (got.hue != e.hue) report("hue", got.hue, e.hue);
			if (got.saturation != e.saturation) report("saturation", got.saturation, e.saturation);
			if (got.lightness_sum != e.lightness_sum)
				report("lightness_sum", got.lightness_sum, e.lightness_sum);
			if (got.tone_class != e.tone_class) report("tone_class", got.tone_class, e.tone_class);
		endfunction

		function void report(string what, int got, int want);
			$display("mismatch %s: got %0d expected %0d", what, got, want);
			errors++;
		endfunction
	endclass

	logic        clk, arst_n, start, busy, done;
	pixel_t      pixel;
	result_t     result;
	logic        psel, penable, pwrite, pready;
	logic [3:0]  paddr;
	logic [31:0] pwdata, prdata;
	hsl_scoreboard sb;
	int          cycles;

	rgb_to_hsl_tone_classifier i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog and result checking
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && done) sb.check_result(result);
		if (cycles > 400000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
		paddr = {idx, 2'b00}; pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, val);
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
	endtask

	// one pixel, held until accepted, optional gap before it
	task automatic send_pixel(pixel_t p, int gap);
		repeat (gap) @(negedge clk);
		start = 1'b1; pixel = p;
		do @(posedge clk); while (busy);
		sb.note_pixel(p);
		@(negedge clk);
		start = 1'b0;
	endtask

	function automatic pixel_t rnd_pixel();
		pixel_t p;
		int     kind;
		kind = $urandom_range(0, 5);
		p = pixel_t'($urandom);
		// near-gray and near-tied channels exercise tolerance edges
		if (kind == 0) begin
			p.green = 8'(p.red + $urandom_range(0, 6) - 3);
			p.blue  = 8'(p.red + $urandom_range(0, 6) - 3);
		end else if (kind == 1) p.green = 8'(p.red + $urandom_range(0, 4) - 2);
		else if (kind == 2) p.blue = 8'(p.green + $urandom_range(0, 4) - 2);
		return p;
	endfunction

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++)
			send_pixel(rnd_pixel(), (i % 50 < 10) ? 0 : $urandom_range(0, 12));
	endtask

	initial begin
		pixel_t dir[$];
		sb = new();
		arst_n = 1'b0; start = 1'b0; pixel = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, each hue sector, half lightness, gray
		dir = '{ {8'd0, 8'd0, 8'd0}, {8'd255, 8'd255, 8'd255}, {8'd255, 8'd0, 8'd0},
			{8'd0, 8'd255, 8'd0}, {8'd0, 8'd0, 8'd255}, {8'd255, 8'd255, 8'd0},
			{8'd255, 8'd0, 8'd255}, {8'd0, 8'd255, 8'd255}, {8'd255, 8'd0, 8'd1},
			{8'd200, 8'd10, 8'd100}, {8'd128, 8'd127, 8'd127}, {8'd255, 8'd0, 8'd128},
			{8'd100, 8'd101, 8'd102}, {8'd2, 8'd1, 8'd0}, {8'd51, 8'd51, 8'd0},
			{8'd170, 8'd85, 8'd85}, {8'd254, 8'd253, 8'd1} };
		foreach (dir[i]) send_pixel(dir[i], i % 3);
		drain();

		// zero tolerance, zero dark and black limits, full white threshold: no-rule hue and zero divisor
		reg_write(REG_EQUAL_TOL, 32'd0);
		reg_write(REG_DARK_SUM, 32'd0);
		reg_write(REG_WHITE_SUM, 32'd510);
		reg_write(REG_BLACK_SUM, 32'd0);
		foreach (dir[i]) send_pixel(dir[i], 0);
		random_phase(400);
		drain();

		// maximum tolerance, dark limit and black threshold, zero white threshold, masked wide writes
		reg_write(REG_EQUAL_TOL, 32'hFFFF_FFFF);
		reg_write(REG_DARK_SUM, 32'h0000_FFFF);
		reg_write(REG_WHITE_SUM, 32'd0);
		reg_write(REG_BLACK_SUM, 32'd510);
		random_phase(300);
		drain();

		// random mid settings
		for (int k = 0; k < 3; k++) begin
			reg_write(REG_EQUAL_TOL, $urandom_range(0, 40));
			reg_write(REG_DARK_SUM, $urandom_range(0, 510));
			reg_write(REG_WHITE_SUM, $urandom_range(0, 510));
			reg_write(REG_BLACK_SUM, $urandom_range(0, 510));
			random_phase(300);
			drain();
		end

		// back to reset values
		reg_write(REG_EQUAL_TOL, 32'd3);
		reg_write(REG_DARK_SUM, 32'd6);
		reg_write(REG_WHITE_SUM, 32'd255);
		reg_write(REG_BLACK_SUM, 32'd102);
		random_phase(400);
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
